// ===== rtl/fractional_delay_line_core_defines.svh =====
// Assertion macros for the fractional delay line core.
// Used by the top level only; no other dependencies.
`ifndef FRACTIONAL_DELAY_LINE_CORE_DEFINES_SVH
`define FRACTIONAL_DELAY_LINE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// cond must hold at every edge outside reset
`define FDL_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("fdl: invariant violated");
// cons must hold in the cycle after ante
`define FDL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fdl: sequence violated");
`else
`define FDL_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define FDL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/fdl_pkg.sv =====
// Shared constants, types and helpers of the fractional delay line.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fdl_pkg;
	localparam int DEPTH         = 1024;
	localparam int FRACTION_BITS = 16;
	localparam int SAMPLE_BITS   = 24;

	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW      = $clog2(DEPTH + 1);
	localparam int DLY_W   = AW + FRACTION_BITS;
	localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int PDATA_W = (DLY_W > 32) ? 64 : 32;
	localparam int ADDR_W  = (DLY_W > 32) ? 4 : 3;
	localparam int RIDX_W  = ADDR_W - ((DLY_W > 32) ? 3 : 2);

	localparam logic [RIDX_W-1:0] REG_DELAY = '0;

	typedef logic [AW-1:0]            idx_t;
	typedef logic [FRACTION_BITS-1:0] frac_t;
	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	// read-head placement from the configuration block
	typedef struct packed {
		logic  load;
		idx_t  idx;
		frac_t frac;
	} head_load_t;

	function automatic idx_t next_idx(input idx_t i);
		next_idx = (i == AW'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
	endfunction
endpackage
`default_nettype wire

// ===== rtl/fractional_delay_line_core.sv =====
// Top level of the fractional delay line: pointers, fill count, store
// access with write forwarding. Depends on fdl_pkg, fdl_store, fdl_cfg,
// fdl_interp and fractional_delay_line_core_defines.svh.
//
// Usage:
//  - Slave stream (s_tvalid/s_tready/s_tdata) carries one signed sample per
//    transaction; master stream (m_*) returns exactly one delayed,
//    linearly interpolated sample per input transaction, in order.
//  - APB port holds the delay register (word 0, unsigned, FRACTION_BITS
//    fraction bits). Writing it saturates to DEPTH-1 samples and places the
//    read head at write pointer minus delay. Write it only while idle.
//  - Throughput: one transaction per cycle while m_tready stays high. Each sample costs
//    one write and two reads of the single sample memory in its accept
//    cycle; the three memory ports set that figure.
//  - Pipeline: the result is valid once it has passed the registered
//    stages memory read, difference, multiply and round-and-add into
//    the output register.
//  - Reset (arst_n low): pointers, fraction and delay clear, pipeline
//    empties. No clearing pass: a fill count marks entries never written,
//    and those read as zero, so samples are taken from the first cycle on.
//  - Receiver stall: the output register holds, bubbles in the pipeline
//    collapse, and s_tready drops once all stages are full.
`timescale 1ns / 1ps
`default_nettype none
`include "fractional_delay_line_core_defines.svh"
module fractional_delay_line_core import fdl_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	// slave stream, s_tdata fields from bit 0: sample_in
	input  wire                s_tvalid,
	output logic               s_tready,
	input  wire [TDATA_W-1:0]  s_tdata,
	// master stream, m_tdata fields from bit 0: sample_out
	output logic               m_tvalid,
	input  wire                m_tready,
	output logic [TDATA_W-1:0] m_tdata,
	// configuration
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire [ADDR_W-1:0]   paddr,
	input  wire [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);
	idx_t            wr_idx_q;
	idx_t            rd_idx_q;
	idx_t            rd_nxt;
	frac_t           frac_q;
	logic [FW-1:0]   fill_q;
	head_load_t      head;

	logic            accept;
	logic            interp_ready;
	sample_t         samp_in;
	sample_t         rd_a;
	sample_t         rd_b;

	// stage 1: memory read data arrives, forwarding flags beside it
	logic            v1_q;
	logic            fwd_a_s1;
	logic            fwd_b_s1;
	logic            ok_a_s1;
	logic            ok_b_s1;
	sample_t         samp_s1;
	frac_t           frac_s1;
	sample_t         a_val;
	sample_t         b_val;

	assign samp_in  = s_tdata[SAMPLE_BITS-1:0];
	assign rd_nxt   = next_idx(rd_idx_q);
	assign s_tready = !v1_q || interp_ready;
	assign accept   = s_tvalid && s_tready;

	fdl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.wr_idx  (wr_idx_q),
		.head    (head)
	);

	// write the new sample and read both taps in the same cycle
	fdl_store u_store (
		.clk     (clk),
		.we      (accept),
		.waddr   (wr_idx_q),
		.wdata   (samp_in),
		.re      (accept),
		.raddr_a (rd_idx_q),
		.raddr_b (rd_nxt),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// advance pointers per sample; move the read head on a delay write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			frac_q   <= '0;
			fill_q   <= '0;
			v1_q     <= 1'b0;
		end else begin
			if (head.load) begin
				rd_idx_q <= head.idx;
				frac_q   <= head.frac;
			end else if (accept) begin
				rd_idx_q <= rd_nxt;
			end
			if (accept) begin
				wr_idx_q <= next_idx(wr_idx_q);
				if (fill_q != FW'(DEPTH)) fill_q <= fill_q + 1'b1;
			end
			if (accept) v1_q <= 1'b1;
			else if (interp_ready) v1_q <= 1'b0;
		end
	end

	// the memory returns old data for the entry written this cycle: forward
	// the incoming sample there; entries never written read as zero
	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_a_s1 <= (rd_idx_q == wr_idx_q);
			fwd_b_s1 <= (rd_nxt == wr_idx_q);
			ok_a_s1  <= (FW'(rd_idx_q) < fill_q);
			ok_b_s1  <= (FW'(rd_nxt) < fill_q);
			samp_s1  <= samp_in;
			frac_s1  <= frac_q;
		end
	end

	always_comb begin
		a_val = fwd_a_s1 ? samp_s1 : (ok_a_s1 ? rd_a : '0);
		b_val = fwd_b_s1 ? samp_s1 : (ok_b_s1 ? rd_b : '0);
	end

	fdl_interp u_interp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v1_q),
		.in_ready (interp_ready),
		.a        (a_val),
		.b        (b_val),
		.frac     (frac_s1),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	`FDL_ASSERT_ALWAYS(a_fill_bound, clk, arst_n, fill_q <= FW'(DEPTH))
	`FDL_ASSERT_ALWAYS(a_idx_bound, clk, arst_n, (rd_idx_q < AW'(DEPTH - 1)) || (rd_idx_q == AW'(DEPTH - 1)))
	`FDL_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, accept, v1_q)
	`FDL_ASSERT_NEXT(a_fill_tracks_wr, clk, arst_n, accept && (fill_q != FW'(DEPTH)), FW'(wr_idx_q) == fill_q || fill_q == FW'(DEPTH))
endmodule
`default_nettype wire

// ===== rtl/fdl_store.sv =====
// Sample memory: one write port, two registered read ports.
// Depends on fdl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fdl_store import fdl_pkg::*; (
	input  wire     clk,
	input  wire     we,
	input  idx_t    waddr,
	input  sample_t wdata,
	input  wire     re,
	input  idx_t    raddr_a,
	input  idx_t    raddr_b,
	output sample_t rdata_a,
	output sample_t rdata_b
);
	sample_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/fdl_cfg.sv =====
// APB register block: delay register, saturation and read-head placement.
// Depends on fdl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fdl_cfg import fdl_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire [ADDR_W-1:0]   paddr,
	input  wire [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  idx_t               wr_idx,
	output head_load_t         head
);
	localparam int PW = DLY_W + 2;
	localparam logic [DLY_W-1:0] DELAY_MAX = {AW'(DEPTH - 1), {FRACTION_BITS{1'b0}}};
	localparam logic [PW-1:0]    SPAN      = PW'(DEPTH) << FRACTION_BITS;

	logic [DLY_W-1:0] delay_q;
	logic [DLY_W-1:0] delay_sat;
	logic [PW-1:0]    pos_raw;
	logic [PW-1:0]    pos;
	logic             sel_delay;
	logic             wr_delay;

	assign pready    = 1'b1;
	assign sel_delay = (paddr[ADDR_W-1:ADDR_W-RIDX_W] == REG_DELAY);
	assign wr_delay  = psel & penable & pwrite & pready & sel_delay;

	assign delay_sat = (pwdata > PDATA_W'(DELAY_MAX)) ? DELAY_MAX : pwdata[DLY_W-1:0];

	always_comb begin
		pos_raw = {2'b00, wr_idx, {FRACTION_BITS{1'b0}}} + SPAN - {2'b00, delay_sat};
		pos     = (pos_raw >= SPAN) ? PW'(pos_raw - SPAN) : pos_raw;
	end

	assign head.load = wr_delay;
	assign head.idx  = pos[DLY_W-1:FRACTION_BITS];
	assign head.frac = pos[FRACTION_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= '0;
		end else if (wr_delay) begin
			delay_q <= delay_sat;
		end
	end

	assign prdata = sel_delay ? PDATA_W'(delay_q) : '0;
endmodule
`default_nettype wire

// ===== rtl/fdl_interp.sv =====
// Interpolation pipeline: difference, weight multiply, round and add,
// ending in the output register. Depends on fdl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fdl_interp import fdl_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  sample_t            a,
	input  sample_t            b,
	input  frac_t              frac,
	output logic               m_tvalid,
	input  wire                m_tready,
	output logic [TDATA_W-1:0] m_tdata
);
	localparam int PRW = SAMPLE_BITS + FRACTION_BITS + 2;

	logic signed [SAMPLE_BITS:0] diff_s2;
	sample_t                     a_s2;
	frac_t                       frac_s2;
	logic                        v2_q;
	logic signed [PRW-1:0]       prod_s3;
	sample_t                     a_s3;
	logic                        v3_q;
	sample_t                     y_q;
	logic                        ov_q;

	logic                        out_free;
	logic                        rdy3;
	logic signed [PRW-1:0]       rnd;
	logic signed [SAMPLE_BITS+1:0] q;
	logic signed [SAMPLE_BITS+1:0] y_wide;

	assign out_free = !ov_q || m_tready;
	assign rdy3     = !v3_q || out_free;
	assign in_ready = !v2_q || rdy3;

	always_comb begin
		rnd    = prod_s3 + PRW'(1 << (FRACTION_BITS - 1));
		q      = rnd[PRW-1:FRACTION_BITS];
		y_wide = $signed({{2{a_s3[SAMPLE_BITS-1]}}, a_s3}) + q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (in_ready) v2_q <= in_valid;
			if (rdy3) v3_q <= v2_q;
			if (out_free) ov_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			diff_s2 <= $signed({b[SAMPLE_BITS-1], b}) - $signed({a[SAMPLE_BITS-1], a});
			a_s2    <= a;
			frac_s2 <= frac;
		end
		if (rdy3) begin
			prod_s3 <= diff_s2 * $signed({1'b0, frac_s2});
			a_s3    <= a_s2;
		end
		if (out_free) begin
			y_q <= y_wide[SAMPLE_BITS-1:0];
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = TDATA_W'($unsigned(y_q));
endmodule
`default_nettype wire
